### sv/three_phase_current_moving_average_top_defines.svh
// assertion macros for the three-phase current filter
`ifndef THREE_PHASE_CURRENT_MOVING_AVERAGE_TOP_DEFINES_SVH
`define THREE_PHASE_CURRENT_MOVING_AVERAGE_TOP_DEFINES_SVH

// implication checked in the following cycle, skipped while in reset
`define TPCMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpcma assertion failed");

// same-cycle implication, skipped while in reset
`define TPCMA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpcma assertion failed");

// implication checked in the following cycle, also during reset
`define TPCMA_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tpcma assertion failed");

`endif

### sv/tpcma_pkg.sv
// shared types and constants of the three-phase current filter
package tpcma_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int RAW_W      = 16;
  localparam int SUM_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PHASES     = 3;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 40;
  localparam int M_PAD_W    = M_TDATA_W - PHASES * SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 12'd4095;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd500;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SELECT   = 3'd0,
    REG_SPIKE_THRESHOLD = 3'd1,
    REG_BIAS_U          = 3'd2,
    REG_BIAS_V          = 3'd3,
    REG_BIAS_W          = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic full;
  } lane_ctl_t;

  typedef struct packed {
    logic a_valid;
    logic win8;
    logic floor_on;
  } merge_ctl_t;

endpackage

### sv/tpcma_lane.sv
// one phase: clamp, spike rejection, sample ring and running sum
module tpcma_lane #(
  parameter int WINDOW_MAX = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tpcma_pkg::lane_ctl_t            ctl,
  input  logic [$clog2(WINDOW_MAX)-1:0]   pos,
  input  logic [tpcma_pkg::RAW_W-1:0]     raw,
  input  tpcma_pkg::sample_t              threshold,
  output tpcma_pkg::sum_t                 sum
);

  localparam int PW = $clog2(WINDOW_MAX);

  tpcma_pkg::sample_t ring [WINDOW_MAX];
  tpcma_pkg::sample_t prev;
  tpcma_pkg::sample_t clamped;
  tpcma_pkg::sample_t oldest;
  tpcma_pkg::sample_t diff;
  tpcma_pkg::sample_t keep;
  tpcma_pkg::sum_t    sum_next;

  always_comb begin
    if (raw > tpcma_pkg::RAW_W'(tpcma_pkg::SAMPLE_MAX)) begin
      clamped = tpcma_pkg::SAMPLE_MAX;
    end else begin
      clamped = raw[tpcma_pkg::SAMPLE_W-1:0];
    end
    oldest = ring[pos[PW-1:0]];
    diff   = (clamped > prev) ? (clamped - prev) : (prev - clamped);
    keep   = (ctl.full && (diff > threshold)) ? prev : clamped;
    if (ctl.full) begin
      sum_next = sum + tpcma_pkg::SUM_W'(keep) - tpcma_pkg::SUM_W'(oldest);
    end else begin
      sum_next = sum + tpcma_pkg::SUM_W'(keep);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      sum <= '0;
    end else if (ctl.load) begin
      sum <= sum_next;
    end
  end

  // ring contents and last stored value
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ring[pos] <= keep;
      prev      <= keep;
    end
  end

endmodule

### sv/tpcma_merge.sv
// output stage: scale the lane sums, clamp, bias floor and result register
module tpcma_merge #(
  parameter int CHANNELS = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tpcma_pkg::merge_ctl_t ctl,
  input  logic                  m_ready,
  input  tpcma_pkg::sum_t       sums [CHANNELS],
  input  tpcma_pkg::sample_t    bias [tpcma_pkg::PHASES],
  output logic                  advance,
  output logic                  m_valid,
  output tpcma_pkg::sample_t    current [tpcma_pkg::PHASES]
);

  tpcma_pkg::sample_t res [tpcma_pkg::PHASES];

  assign advance = ctl.a_valid && (!m_valid || m_ready);

  for (genvar ch = 0; ch < tpcma_pkg::PHASES; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_used
      logic [tpcma_pkg::SUM_W-3:0] scaled;
      tpcma_pkg::sample_t          capped;
      always_comb begin
        if (ctl.win8) begin
          scaled = (tpcma_pkg::SUM_W-2)'(sums[ch] >> 3);
        end else begin
          scaled = (tpcma_pkg::SUM_W-2)'(sums[ch] >> 2);
        end
        if (scaled > (tpcma_pkg::SUM_W-2)'(tpcma_pkg::SAMPLE_MAX)) begin
          capped = tpcma_pkg::SAMPLE_MAX;
        end else begin
          capped = scaled[tpcma_pkg::SAMPLE_W-1:0];
        end
        if (ctl.floor_on && (capped < bias[ch])) begin
          res[ch] = bias[ch];
        end else begin
          res[ch] = capped;
        end
      end
    end else begin : g_unused
      assign res[ch] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      current <= res;
    end
  end

endmodule

### sv/three_phase_current_moving_average_top.sv
// top level of the three-phase current moving-average filter
//
// input stream: one request carries a U/V/W sample triple in s_axis_tdata and
// the motor run flag in s_axis_tuser. output stream: one filtered triple per
// request in m_axis_tdata.
// each phase has its own lane (clamp to 4095, spike rejection against the last
// stored sample, 4- or 8-entry ring with running sum); the output stage scales
// the sums, clamps and applies the bias floor in window-4 mode while running.
// a request is held in the lane sums with its valid flag, then in the output
// result register on m_axis. throughput: one request per cycle while m_axis
// is not stalled; each lane updates its ring and sum as a request is taken.
// the lane sums act as a holding stage, so a new request is taken while a
// finished result waits on m_axis; if the receiver stalls with both stages
// full, s_axis_tready drops until the result is taken.
// reset clears sums, ring position, fill count and both valid flags and loads
// register defaults (threshold 500, window 4, biases 0). a window write
// restarts filling. users write configuration only when idle; not enforced.
module three_phase_current_moving_average_top #(
  parameter int WINDOW_MAX = 8,
  parameter int CHANNELS   = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_u [15:0], sample_v [31:16], sample_w [47:32]
  input  logic [tpcma_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // motor_running [0]
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // current_u [11:0], current_v [23:12], current_w [35:24], zero [39:36]
  output logic [tpcma_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [tpcma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpcma_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW        = $clog2(WINDOW_MAX);
  localparam int FW        = $clog2(WINDOW_MAX + 1);
  localparam int WLEN_LONG = (WINDOW_MAX >= 8) ? 8 : 4;

  logic               window_select;
  tpcma_pkg::sample_t spike_threshold;
  tpcma_pkg::sample_t bias [tpcma_pkg::PHASES];

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [FW-1:0] fill;
  logic          a_valid;
  logic          a_motor;

  logic                  win8;
  logic                  full;
  logic                  accept;
  logic                  advance;
  logic                  restart;
  tpcma_pkg::lane_ctl_t  lane_ctl;
  tpcma_pkg::merge_ctl_t merge_ctl;
  tpcma_pkg::sum_t       sums [CHANNELS];
  tpcma_pkg::sample_t    current [tpcma_pkg::PHASES];

  assign win8    = window_select && (WINDOW_MAX >= 8);
  assign full    = win8 ? (fill >= FW'(WLEN_LONG)) : (fill >= FW'(4));
  assign restart = cfg_we && (cfg_index == tpcma_pkg::REG_WINDOW_SELECT);

  assign s_axis_tready = !a_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (win8 ? (pos == PW'(WLEN_LONG - 1)) : (pos == PW'(3))) begin
      pos_next = '0;
    end else begin
      pos_next = pos + PW'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_select   <= 1'b0;
      spike_threshold <= tpcma_pkg::THRESHOLD_RESET;
      bias[0]         <= '0;
      bias[1]         <= '0;
      bias[2]         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpcma_pkg::REG_WINDOW_SELECT:   window_select   <= cfg_data[0];
        tpcma_pkg::REG_SPIKE_THRESHOLD: spike_threshold <= cfg_data;
        tpcma_pkg::REG_BIAS_U:          bias[0]         <= cfg_data;
        tpcma_pkg::REG_BIAS_V:          bias[1]         <= cfg_data;
        tpcma_pkg::REG_BIAS_W:          bias[2]         <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared ring position and fill count
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos  <= '0;
      fill <= '0;
    end else if (accept) begin
      pos <= pos_next;
      if (!full) begin
        fill <= fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_motor <= s_axis_tuser[0];
    end
  end

  assign lane_ctl = '{load: accept, restart: restart, full: full};

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    tpcma_lane #(
      .WINDOW_MAX (WINDOW_MAX)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (lane_ctl),
      .pos       (pos),
      .raw       (s_axis_tdata[ch*tpcma_pkg::RAW_W +: tpcma_pkg::RAW_W]),
      .threshold (spike_threshold),
      .sum       (sums[ch])
    );
  end

  assign merge_ctl = '{a_valid: a_valid, win8: win8,
                       floor_on: !window_select && a_motor};

  tpcma_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctl     (merge_ctl),
    .m_ready (m_axis_tready),
    .sums    (sums),
    .bias    (bias),
    .advance (advance),
    .m_valid (m_axis_tvalid),
    .current (current)
  );

  assign m_axis_tdata = {{tpcma_pkg::M_PAD_W{1'b0}}, current[2], current[1], current[0]};

endmodule

### sv/tpcma_checker.sv
// port-level checks of the three-phase current filter and their binding
`include "three_phase_current_moving_average_top_defines.svh"

module tpcma_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tpcma_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // nothing offered right after reset
  `TPCMA_ASSERT_ALWAYS(a_reset_clears, clk, rst, !m_axis_tvalid)

  // a stalled result holds
  `TPCMA_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // with the output empty the block always takes a request
  `TPCMA_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

  // every taken request is checked to reach m_axis as a valid result
  `TPCMA_ASSERT_NEXT(a_latency, clk, rst, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid)

endmodule

bind three_phase_current_moving_average_top tpcma_checker u_tpcma_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
